[rtl/mjdc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MJD to calendar date package
// Shared types and calendar constants for the date conversion pipeline.
// ----------------------------------------------------------------------------
package mjdc_pkg;

  // Width of the day count from 0001-01-01.
  localparam int unsigned DayW = 22;

  // MJD of 9999-12-31 and the offset that maps MJD onto the day count.
  localparam logic signed [22:0] MjdMax      = 23'sd2973483;
  localparam logic signed [23:0] EpochOffset = 24'sd678575;

  localparam int unsigned Days400Y = 146097;
  localparam int unsigned Days100Y = 36524;
  localparam int unsigned Days4Y   = 1461;
  localparam int unsigned Days1Y   = 365;

  // Load enables for the three stages of a constant divider.
  typedef struct packed {
    logic est;
    logic sub;
    logic fix;
  } div_en_t;

  // Year-period counts that travel down the pipeline with each request.
  typedef struct packed {
    logic [4:0] n400;
    logic [1:0] n100;
  } cent_t;

  // Zero-based day of year on which month m (0..11) starts.
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] base;
    begin
      case (m)
        4'd0:    base = 9'd0;
        4'd1:    base = 9'd31;
        4'd2:    base = 9'd59;
        4'd3:    base = 9'd90;
        4'd4:    base = 9'd120;
        4'd5:    base = 9'd151;
        4'd6:    base = 9'd181;
        4'd7:    base = 9'd212;
        4'd8:    base = 9'd243;
        4'd9:    base = 9'd273;
        4'd10:   base = 9'd304;
        4'd11:   base = 9'd334;
        default: base = 9'd0;
      endcase
      if (leap && (m >= 4'd2) && (m <= 4'd11)) begin
        base = base + 9'd1;
      end
      return base;
    end
  endfunction

endpackage

[rtl/mjdc_cdiv.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined divider by a constant
// Three stages: reciprocal estimate, remainder, and a single correction step.
// ----------------------------------------------------------------------------
module mjdc_cdiv #(
  parameter int unsigned AW  = 22,
  parameter int unsigned DIV = 146097,
  parameter int unsigned QW  = 5
) (
  input  logic                      clk_i,
  input  mjdc_pkg::div_en_t         en_i,
  input  logic [AW-1:0]             a_i,
  output logic [QW-1:0]             q_o,
  output logic [$clog2(DIV)-1:0]    r_o
);

  import mjdc_pkg::*;

  localparam int unsigned RW = $clog2(DIV);
  localparam int unsigned M  = (2 ** AW) / DIV;
  localparam int unsigned MW = $clog2(M + 1);
  localparam int unsigned PW = AW + MW;

  // The estimate floor(a * M / 2^AW) is never high and at most one low.
  logic [PW-1:0] prod_a;
  logic [AW-1:0] a_a_q;
  logic [QW-1:0] q_a_d, q_a_q;

  logic [AW-1:0] qd_b, diff_b;
  logic [RW:0]   r_b_d, r_b_q;
  logic [QW-1:0] q_b_q;

  logic [RW-1:0] r_c_d, r_c_q;
  logic [QW-1:0] q_c_d, q_c_q;

  always_comb begin
    prod_a = PW'(a_i) * PW'(M);
    q_a_d  = prod_a[AW +: QW];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.est) begin
      a_a_q <= a_i;
      q_a_q <= q_a_d;
    end
  end

  always_comb begin
    qd_b   = AW'(q_a_q) * AW'(DIV);
    diff_b = a_a_q - qd_b;
    r_b_d  = diff_b[RW:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sub) begin
      r_b_q <= r_b_d;
      q_b_q <= q_a_q;
    end
  end

  always_comb begin
    if (r_b_q >= (RW+1)'(DIV)) begin
      r_c_d = RW'(r_b_q - (RW+1)'(DIV));
      q_c_d = q_b_q + QW'(1);
    end else begin
      r_c_d = r_b_q[RW-1:0];
      q_c_d = q_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.fix) begin
      r_c_q <= r_c_d;
      q_c_q <= q_c_d;
    end
  end

  assign q_o = q_c_q;
  assign r_o = r_c_q;

endmodule

[rtl/mjd_to_calendar_date_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MJD to Gregorian calendar date converter
// Throughput: one request per cycle; eleven register stages, each with a
// valid bit, and a stage only holds when the stage after it is full.
// Reset: rst_ni clears all valid bits at once; data registers are not reset.
// ----------------------------------------------------------------------------
module mjd_to_calendar_date_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [22:0] day_number_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic               valid_res_o,
  output logic [13:0]        year_o,
  output logic [3:0]         month_o,
  output logic [4:0]         day_of_month_o,
  output logic [8:0]         day_of_year_o
);

  import mjdc_pkg::*;

  // Pipeline map:
  //   1      day count from 0001-01-01 and range check
  //   2..4   division by the 400-year period (estimate, remainder, fix)
  //   5      century index by comparison, clamped at three
  //   6..8   division by the four-year period
  //   9      year within the four-year block, leap flag
  //   10     year sum, month index, day of year
  //   11     day of month and output register
  localparam int unsigned NS = 11;

  logic [NS:1] v_q;
  logic [NS:1] ok_q;
  logic [NS:1] adv;
  logic [NS:1] v_prev;
  logic [NS:1] ok_prev;

  // A stage may load when it is empty or when its content moves on. The
  // output stage is the only one that sees the downstream stall.
  always_comb begin
    adv[NS] = !v_q[NS] || !stall_i;
    for (int k = NS - 1; k >= 1; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign stall_o = !adv[1];
  assign valid_o = v_q[NS];

  // Stage 1: map MJD onto a day count and check the supported range.
  logic signed [23:0] days_s1;
  logic               ok_s1;
  logic [DayW-1:0]    d1_d, d1_q;

  always_comb begin
    days_s1 = 24'(day_number_i) + EpochOffset;
    ok_s1   = (day_number_i <= MjdMax) && !days_s1[23];
    // Out-of-range requests run through the pipe as day zero.
    d1_d    = ok_s1 ? days_s1[DayW-1:0] : '0;
  end

  assign v_prev  = {v_q[NS-1:1], valid_i};
  assign ok_prev = {ok_q[NS-1:1], ok_s1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (adv & v_prev) | (~adv & v_q);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 1; k <= NS; k++) begin
      if (adv[k]) begin
        ok_q[k] <= ok_prev[k];
      end
    end
    if (adv[1]) begin
      d1_q <= d1_d;
    end
  end

  // Stages 2..4: 400-year periods.
  div_en_t          en400;
  logic [4:0]       n400_w;
  logic [17:0]      r400_w;

  assign en400 = '{est: adv[2], sub: adv[3], fix: adv[4]};

  mjdc_cdiv #(
    .AW  (DayW),
    .DIV (Days400Y),
    .QW  (5)
  ) u_div400 (
    .clk_i (clk_i),
    .en_i  (en400),
    .a_i   (d1_q),
    .q_o   (n400_w),
    .r_o   (r400_w)
  );

  // Stage 5: centuries. The last day of a 400-year period falls into the
  // fourth century, which is why the index stops at three.
  logic [1:0]  n100_s5;
  logic [17:0] sub_s5;
  logic [17:0] r5_w;
  cent_t       cent5_q, cent6_q, cent7_q, cent8_q, cent9_q;
  logic [15:0] r5_q;

  always_comb begin
    if (r400_w >= 18'(3 * Days100Y)) begin
      n100_s5 = 2'd3;
      sub_s5  = 18'(3 * Days100Y);
    end else if (r400_w >= 18'(2 * Days100Y)) begin
      n100_s5 = 2'd2;
      sub_s5  = 18'(2 * Days100Y);
    end else if (r400_w >= 18'(Days100Y)) begin
      n100_s5 = 2'd1;
      sub_s5  = 18'(Days100Y);
    end else begin
      n100_s5 = 2'd0;
      sub_s5  = '0;
    end
    r5_w = r400_w - sub_s5;
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      cent5_q.n400 <= n400_w;
      cent5_q.n100 <= n100_s5;
      r5_q         <= r5_w[15:0];
    end
    if (adv[6]) begin
      cent6_q <= cent5_q;
    end
    if (adv[7]) begin
      cent7_q <= cent6_q;
    end
    if (adv[8]) begin
      cent8_q <= cent7_q;
    end
  end

  // Stages 6..8: four-year blocks within the century.
  div_en_t     en4;
  logic [4:0]  n4_w;
  logic [10:0] r4y_w;

  assign en4 = '{est: adv[6], sub: adv[7], fix: adv[8]};

  mjdc_cdiv #(
    .AW  (16),
    .DIV (Days4Y),
    .QW  (5)
  ) u_div4 (
    .clk_i (clk_i),
    .en_i  (en4),
    .a_i   (r5_q),
    .q_o   (n4_w),
    .r_o   (r4y_w)
  );

  // Stage 9: year within the block, again clamped at three. The fourth
  // year of a block is leap, except in the last block of a century that
  // is not the fourth century of its 400-year period.
  logic [1:0]  n1_s9;
  logic [10:0] sub_s9;
  logic [10:0] r9_w;
  logic        leap_s9;
  logic [4:0]  n4_9_q;
  logic [1:0]  n1_9_q;
  logic        leap9_q;
  logic [8:0]  r9_q;

  always_comb begin
    if (r4y_w >= 11'(3 * Days1Y)) begin
      n1_s9  = 2'd3;
      sub_s9 = 11'(3 * Days1Y);
    end else if (r4y_w >= 11'(2 * Days1Y)) begin
      n1_s9  = 2'd2;
      sub_s9 = 11'(2 * Days1Y);
    end else if (r4y_w >= 11'(Days1Y)) begin
      n1_s9  = 2'd1;
      sub_s9 = 11'(Days1Y);
    end else begin
      n1_s9  = 2'd0;
      sub_s9 = '0;
    end
    r9_w    = r4y_w - sub_s9;
    leap_s9 = (n1_s9 == 2'd3) && ((n4_w != 5'd24) || (cent8_q.n100 == 2'd3));
  end

  always_ff @(posedge clk_i) begin
    if (adv[9]) begin
      cent9_q <= cent8_q;
      n4_9_q  <= n4_w;
      n1_9_q  <= n1_s9;
      leap9_q <= leap_s9;
      r9_q    <= r9_w[8:0];
    end
  end

  // Stage 10: assemble the year, find the month by counting the month
  // starts that the day index has passed.
  logic [13:0] year_s10;
  logic [3:0]  mon_s10;
  logic [13:0] year10_q;
  logic [3:0]  mon10_q;
  logic        leap10_q;
  logic [8:0]  r10_q;
  logic [8:0]  doy10_q;

  always_comb begin
    year_s10 = 14'(cent9_q.n400) * 14'd400 + 14'(cent9_q.n100) * 14'd100
             + 14'(n4_9_q) * 14'd4 + 14'(n1_9_q) + 14'd1;
    mon_s10  = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (r9_q >= month_start(4'(m), leap9_q)) begin
        mon_s10 = mon_s10 + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[10]) begin
      year10_q <= year_s10;
      mon10_q  <= mon_s10;
      leap10_q <= leap9_q;
      r10_q    <= r9_q;
      doy10_q  <= r9_q + 9'd1;
    end
  end

  // Stage 11: day of month, and zeroed fields for out-of-range dates.
  logic [8:0] dom_s11;
  logic [13:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  dom_q;
  logic [8:0]  doy_q;

  assign dom_s11 = r10_q - month_start(mon10_q, leap10_q) + 9'd1;

  always_ff @(posedge clk_i) begin
    if (adv[11]) begin
      if (ok_q[10]) begin
        year_q  <= year10_q;
        month_q <= mon10_q + 4'd1;
        dom_q   <= dom_s11[4:0];
        doy_q   <= doy10_q;
      end else begin
        year_q  <= '0;
        month_q <= '0;
        dom_q   <= '0;
        doy_q   <= '0;
      end
    end
  end

  assign valid_res_o    = ok_q[NS];
  assign year_o         = year_q;
  assign month_o        = month_q;
  assign day_of_month_o = dom_q;
  assign day_of_year_o  = doy_q;

  // The input side only stalls once every stage holds a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (&v_q))
    else $error("input stalled while a pipeline stage is empty");

  // Out-of-range dates come out with all calendar fields cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !valid_res_o) |->
      (year_o == 14'd0 && month_o == 4'd0 && day_of_month_o == 5'd0
       && day_of_year_o == 9'd0))
    else $error("invalid date with nonzero fields");

  // A valid date lies within the calendar's ranges.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && valid_res_o) |->
      (year_o >= 14'd1 && year_o <= 14'd9999 && month_o >= 4'd1
       && month_o <= 4'd12 && day_of_month_o >= 5'd1
       && day_of_year_o >= 9'd1 && day_of_year_o <= 9'd366))
    else $error("calendar field out of range");

  // February never runs past the 29th.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && valid_res_o && month_o == 4'd2) |-> (day_of_month_o <= 5'd29))
    else $error("February day out of range");

endmodule
